/* design/gcl_pkg.sv */
// Package for the gcd/lcm unit: request and response word types, controller states,
// and the command and status structs between controller and datapath.
// No dependencies.
package gcl_pkg;

   // Request word: the two unsigned operands.
   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_word_type;

   // Response word: greatest common divisor and least common multiple.
   typedef struct packed {
      logic [31:0] gcd_value;
      logic [63:0] lcm_value;
   } rsp_word_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_REM_DIV,
      ST_STEP,
      ST_QUO_DIV,
      ST_MULT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;          // capture operands, clear the lcm
      logic div_load;      // start a division
      logic div_sel_final; // divide operand a by the gcd instead of x by y
      logic div_step;      // one restoring division step
      logic euclid_update; // (x, y) becomes (y, x mod y)
      logic mult;          // lcm = quotient times operand b
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic y_zero;   // Euclid loop has finished
      logic ops_zero; // one of the operands is zero
      logic div_last; // the current division step is the last one
   } status_type;

endpackage

/* design/gcl_top.sv */
// Greatest common divisor and least common multiple of two unsigned operands.
// When both operands are non-zero, k Euclid remainder divisions are followed by a final
// division of operand a by the gcd and the multiply; when only the first is zero there is one
// remainder division, and none when the second is zero; every division takes one quotient bit a cycle.
// One word at a time: the next word is taken in the cycle after the strobe.
// Synchronous reset returns the controller to idle; uses gcl_pkg, gcl_ctrl, gcl_datapath.
module gcd_lcm_unit_core #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gcl_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output gcl_pkg::rsp_word_type rsp_word
);
   import gcl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller.
   gcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath.
   gcl_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

   // The result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted word makes the unit busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a word");

   // A result appears only while a word is in progress.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // A non-zero lcm comes only with a non-zero gcd.
   a_lcm_gcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.lcm_value != '0)) |-> (rsp_word.gcd_value != '0))
      else $error("non-zero lcm with zero gcd");

endmodule

/* design/gcl_ctrl.sv */
// Controller state machine of the gcd/lcm unit.
// Sequences the Euclid remainder loop, the final division and the multiply.
// Depends on gcl_pkg.
module gcl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  gcl_pkg::status_type status,
   output gcl_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import gcl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!status.y_zero) begin
               state_in = ST_REM_DIV;
            end else if (status.ops_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_QUO_DIV;
            end
         end
         ST_REM_DIV: begin
            if (status.div_last) state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = ST_TEST;
         end
         ST_QUO_DIV: begin
            if (status.div_last) state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_TEST: begin
            if (!status.y_zero) begin
               cmd.div_load = 1'b1;
            end else if (!status.ops_zero) begin
               cmd.div_load      = 1'b1;
               cmd.div_sel_final = 1'b1;
            end
         end
         ST_REM_DIV, ST_QUO_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_STEP: begin
            cmd.euclid_update = 1'b1;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* design/gcl_datapath.sv */
// Datapath of the gcd/lcm unit: operand and Euclid registers, a shared
// radix-2 restoring divider and the lcm multiplier.
// Depends on gcl_pkg.
module gcl_datapath #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                  clock,
   input  gcl_pkg::req_word_type req_word,
   input  gcl_pkg::cmd_type      cmd,
   output gcl_pkg::status_type   status,
   output gcl_pkg::rsp_word_type rsp_word
);
   import gcl_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   logic [W-1:0]     a_ff, b_ff, x_ff, y_ff;
   logic [W-1:0]     divisor_ff;
   logic [2*W-1:0]   rq_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [2*W-1:0]   lcm_ff;

   logic [W:0]       trial;
   logic [2*W-1:0]   rq_in;
   logic [W-1:0]     remainder;
   logic [W-1:0]     quotient;

   assign remainder = rq_ff[2*W-1:W];
   assign quotient  = rq_ff[W-1:0];

   // One restoring step: shift in the next dividend bit and try the subtraction.
   always_comb begin
      trial = rq_ff[2*W-1:W-1] - {1'b0, divisor_ff};
      if (!trial[W]) begin
         rq_in = {trial[W-1:0], rq_ff[W-2:0], 1'b1};
      end else begin
         rq_in = {rq_ff[2*W-2:0], 1'b0};
      end
   end

   // Operand and Euclid registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_word.operand_a[W-1:0];
         b_ff <= req_word.operand_b[W-1:0];
         x_ff <= req_word.operand_a[W-1:0];
         y_ff <= req_word.operand_b[W-1:0];
      end else if (cmd.euclid_update) begin
         x_ff <= y_ff;
         y_ff <= remainder;
      end
   end

   // Shared divider: remainder in the upper half, dividend turning into quotient below.
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         cnt_ff <= '0;
         if (cmd.div_sel_final) begin
            rq_ff      <= {{W{1'b0}}, a_ff};
            divisor_ff <= x_ff;
         end else begin
            rq_ff      <= {{W{1'b0}}, x_ff};
            divisor_ff <= y_ff;
         end
      end else if (cmd.div_step) begin
         rq_ff  <= rq_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Least common multiple: (a / gcd) times b, cleared for each new word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lcm_ff <= '0;
      end else if (cmd.mult) begin
         lcm_ff <= (2*W)'(quotient) * (2*W)'(b_ff);
      end
   end

   assign status.y_zero   = (y_ff == '0);
   assign status.ops_zero = (a_ff == '0) || (b_ff == '0);
   assign status.div_last = (cnt_ff == CNT_LAST);

   assign rsp_word.gcd_value = 32'(x_ff);
   assign rsp_word.lcm_value = 64'(lcm_ff);

endmodule
